@@ rtl/msl_pkg.sv @@
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types, codes and waveform tables for the MIDI clock synced LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

    localparam int PERIOD_POINTS = 24;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 7;

    // MIDI realtime bytes
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LFO_ENABLE = 3'd0,
        REG_WAVEFORM   = 3'd1,
        REG_AMPLITUDE  = 3'd2,
        REG_OFFSET     = 3'd3,
        REG_RATE       = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_RANDOM   = 2'd3
    } wave_t;

    typedef struct packed {
        logic       lfo_enable;
        wave_t      waveform;
        logic [6:0] amplitude;
        logic [6:0] offset;
        logic [3:0] rate;
    } cfg_t;

    function automatic logic [5:0] sine_quarter(input logic [2:0] q);
        logic [5:0] v;
        unique case (q)
            3'd0:    v = 6'h05;
            3'd1:    v = 6'h21;
            3'd2:    v = 6'h2E;
            3'd3:    v = 6'h37;
            3'd4:    v = 6'h3C;
            3'd5:    v = 6'h3F;
            default: v = 6'h00;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] tri_quarter(input logic [2:0] q);
        logic [5:0] v;
        unique case (q)
            3'd0:    v = 6'h05;
            3'd1:    v = 6'h10;
            3'd2:    v = 6'h1C;
            3'd3:    v = 6'h28;
            3'd4:    v = 6'h33;
            3'd5:    v = 6'h3F;
            default: v = 6'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/msl_cfg.sv @@
// ----------------------------------------------------------------------------
// msl_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_cfg
    import msl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output      cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lfo_enable <= 1'b0;
            cfg_reg.waveform   <= WAVE_SINE;
            cfg_reg.amplitude  <= 7'd127;
            cfg_reg.offset     <= 7'd64;
            cfg_reg.rate       <= 4'd0;
        end
        else if (cfg_valid)
        begin
            // out of range indexes are dropped
            unique case (cfg_index)
                REG_LFO_ENABLE: cfg_reg.lfo_enable <= cfg_data[0];
                REG_WAVEFORM:   cfg_reg.waveform   <= wave_t'(cfg_data[1:0]);
                REG_AMPLITUDE:  cfg_reg.amplitude  <= cfg_data[6:0];
                REG_OFFSET:     cfg_reg.offset     <= cfg_data[6:0];
                REG_RATE:       cfg_reg.rate       <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/msl_wave.sv @@
// ----------------------------------------------------------------------------
// msl_wave
// One waveform point: quarter table lookup, scaling, offset and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_wave
    import msl_pkg::*;
(
    input  wire logic [4:0] phase,
    input  wire logic [6:0] sample,
    input  wire cfg_t       cfg,
    output      logic [6:0] value
);

    logic [2:0]  quarter_idx;
    logic        negative;
    logic [5:0]  table_val;
    logic [12:0] product;
    logic [6:0]  wave_mag;
    logic [7:0]  sum;

    // mirror the quarter index in the second and fourth quarters
    always_comb
    begin
        priority if (phase < 5'd6)
            quarter_idx = phase[2:0];
        else if (phase < 5'd12)
            quarter_idx = 3'(5'd11 - phase);
        else if (phase < 5'd18)
            quarter_idx = 3'(phase - 5'd12);
        else
            quarter_idx = 3'(5'd23 - phase);
    end

    assign negative  = (phase >= 5'd12);
    assign table_val = (cfg.waveform == WAVE_TRIANGLE) ? tri_quarter(quarter_idx)
                                                       : sine_quarter(quarter_idx);
    assign product   = 13'(cfg.amplitude) * 13'(table_val);

    always_comb
    begin
        unique case (cfg.waveform)
            WAVE_RANDOM:  wave_mag = sample;
            WAVE_SQUARE:  wave_mag = cfg.amplitude;
            default:      wave_mag = product[12:6];
        endcase
    end

    assign sum = 8'(wave_mag) + 8'(cfg.offset);

    always_comb
    begin
        if (!negative)
            value = sum[7] ? 7'd127 : sum[6:0];
        else
            value = (wave_mag > cfg.offset) ? 7'd0 : 7'(cfg.offset - wave_mag);
    end

endmodule

`default_nettype wire

@@ rtl/midi_synced_lfo.sv @@
// ----------------------------------------------------------------------------
// midi_synced_lfo
// LFO stepped by MIDI realtime bytes, one point every rate*2+2 MIDI clock bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one MIDI realtime byte plus a random sample per transfer
//                 (in_valid / in_ready). Clock, start, continue and stop
//                 bytes are acted on, all other bytes are ignored.
//   out channel : lfo_value (out_valid / out_ready), sent only when a new
//                 point differs from the last value sent.
//   cfg channel : register writes (cfg_valid / cfg_ready, cfg_index,
//                 cfg_data), always ready, issued while the block is idle.
// Timing: out_valid shows a result in the cycle after its input transfer.
//   Throughput: one input per cycle unless stalled; all state updates
//   happen in the accepting cycle, the output register holds the result.
// Stall: while out_valid is held by a low out_ready, in_ready follows
//   out_ready, so a new input is taken in the cycle the result drains.
// Reset: stopped, counter and phase at zero, last value zero; registers
//   come up disabled, sine, amplitude 127, offset 64, rate 0.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_synced_lfo
    import msl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [7:0]             realtime_byte,
    input  wire logic [6:0]             random_sample,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [6:0]             lfo_value,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    logic       playing_reg, playing_next;
    logic       waiting_reg, waiting_next;
    logic       due_reg, due_next;
    logic [7:0] tick_reg, tick_next;
    logic [4:0] phase_reg, phase_next;
    logic [6:0] last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] value_reg, value_next;

    logic       in_fire;
    logic [4:0] phase_mid;
    logic [6:0] point_value;
    logic       emit;

    msl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msl_wave u_wave (
        .phase  (phase_mid),
        .sample (random_sample),
        .cfg    (cfg),
        .value  (point_value)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign lfo_value = value_reg;

    always_comb
    begin
        playing_next = playing_reg;
        waiting_next = waiting_reg;
        due_next     = due_reg;
        tick_next    = tick_reg;
        phase_mid    = phase_reg;
        phase_next   = phase_reg;
        last_next    = last_reg;
        emit         = 1'b0;

        if (in_fire)
        begin
            if (realtime_byte == RT_CLOCK)
            begin
                waiting_next = 1'b0;
                if (playing_reg)
                begin
                    tick_next = tick_reg - 8'd1;
                    if (tick_next == 8'd0)
                        due_next = 1'b1;
                end
            end
            else if (playing_reg)
            begin
                if (realtime_byte == RT_STOP)
                    playing_next = 1'b0;
            end
            else if (realtime_byte == RT_START || realtime_byte == RT_CONTINUE)
            begin
                if (realtime_byte == RT_START)
                    phase_mid = 5'd0;
                playing_next = 1'b1;
            end

            phase_next = phase_mid;

            // point computed from the phase left after this byte
            if (cfg.lfo_enable && due_next && !waiting_next)
            begin
                due_next     = 1'b0;
                waiting_next = 1'b1;
                phase_next   = (phase_mid >= 5'(PERIOD_POINTS - 1)) ? 5'd0 : phase_mid + 5'd1;
                tick_next    = {3'b000, cfg.rate, 1'b0} + 8'd2;
                if (point_value != last_reg)
                begin
                    emit      = 1'b1;
                    last_next = point_value;
                end
            end
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (emit)
            value_next = point_value;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg   <= 1'b0;
            waiting_reg   <= 1'b0;
            due_reg       <= 1'b0;
            tick_reg      <= 8'd0;
            phase_reg     <= 5'd0;
            last_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            playing_reg   <= playing_next;
            waiting_reg   <= waiting_next;
            due_reg       <= due_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ dv/midi_synced_lfo_test.sv @@
// ----------------------------------------------------------------------------
// midi_synced_lfo_test
// Self-checking bench for the MIDI clock synced LFO. A directed table walks the
// transport bytes, the tick counter wrap, the pending point and the clamps. A
// random part follows under several register settings. Every lfo_value
// transfer is compared with a value given by the table or predicted from
// the bench's own copy of the LFO state.
// ----------------------------------------------------------------------------
module midi_synced_lfo_test;
    import msl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 146;
    localparam int DRAIN_CYCLES = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd5;

    localparam logic [5:0] SINE_Q [0:5] = '{6'h05, 6'h21, 6'h2E, 6'h37, 6'h3C, 6'h3F};
    localparam logic [5:0] TRI_Q  [0:5] = '{6'h05, 6'h10, 6'h1C, 6'h28, 6'h33, 6'h3F};

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] code;   // midi byte, or register index
        logic [6:0] arg;    // random sample, or register data
        logic [8:0] count;
        logic       typed;
        logic [6:0] want;
    } stim_row_t;

    localparam int NUM_ROWS = 28;
    localparam stim_row_t DIRECTED [0:NUM_ROWS-1] = '{
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd1,   1'b0, 7'd0},   // clock while stopped
        '{ROW_ITEM, 8'h00,                  7'h7F, 9'd1,   1'b0, 7'd0},   // ignored byte
        '{ROW_ITEM, RT_STOP,                7'h00, 9'd1,   1'b0, 7'd0},   // stop while stopped
        '{ROW_ITEM, RT_CONTINUE,            7'h00, 9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, RT_START,               7'h00, 9'd1,   1'b0, 7'd0},   // start while playing
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd256, 1'b0, 7'd0},   // wrap, point held
        '{ROW_REG,  8'(REG_LFO_ENABLE),     7'd1,  9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, 8'hFF,                  7'h00, 9'd1,   1'b1, 7'd73},  // held point fires
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd1,   1'b1, 7'd127}, // clamp high
        '{ROW_REG,  8'(REG_WAVEFORM),       7'(WAVE_TRIANGLE), 9'd1, 1'b0, 7'd0},
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd24,  1'b0, 7'd0},
        '{ROW_REG,  8'(REG_WAVEFORM),       7'(WAVE_SQUARE), 9'd1, 1'b0, 7'd0},
        '{ROW_REG,  8'(REG_OFFSET),         7'd0,  9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd24,  1'b0, 7'd0},   // clamp low
        '{ROW_REG,  8'(REG_WAVEFORM),       7'(WAVE_RANDOM), 9'd1, 1'b0, 7'd0},
        '{ROW_REG,  8'(REG_OFFSET),         7'd127, 9'd1,  1'b0, 7'd0},
        '{ROW_ITEM, RT_CLOCK,               7'h55, 9'd8,   1'b0, 7'd0},   // repeated values
        '{ROW_ITEM, RT_STOP,                7'h00, 9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, RT_CLOCK,               7'h2A, 9'd4,   1'b0, 7'd0},   // counter frozen
        '{ROW_REG,  8'(REG_AMPLITUDE),      7'd0,  9'd1,   1'b0, 7'd0},
        '{ROW_REG,  8'(REG_WAVEFORM),       7'(WAVE_SINE), 9'd1, 1'b0, 7'd0},
        '{ROW_REG,  8'(REG_OFFSET),         7'd64, 9'd1,   1'b0, 7'd0},
        '{ROW_ITEM, RT_START,               7'h00, 9'd1,   1'b0, 7'd0},   // phase back to 0
        '{ROW_ITEM, RT_CLOCK,               7'h00, 9'd6,   1'b0, 7'd0},
        '{ROW_REG,  8'(REG_UNMAPPED),       7'h7F, 9'd1,   1'b0, 7'd0},   // ignored write
        '{ROW_REG,  8'(REG_LFO_ENABLE),     7'd0,  9'd1,   1'b0, 7'd0},
        '{ROW_REG,  8'(REG_RATE),           7'd15, 9'd1,   1'b0, 7'd0}
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [7:0]             realtime_byte = 8'h00;
    logic [6:0]             random_sample = 7'h00;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [6:0]             lfo_value;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // register copies
    logic       lfo_on     = 1'b0;
    wave_t      wave_sel   = WAVE_SINE;
    logic [6:0] amp_set    = 7'd127;
    logic [6:0] offset_set = 7'd64;
    logic [3:0] rate_set   = 4'd0;

    // lfo state copy
    logic       running       = 1'b0;
    logic       await_tick    = 1'b0;
    logic       point_pending = 1'b0;
    logic [7:0] tick_count    = 8'd0;
    logic [4:0] lfo_phase     = 5'd0;
    logic [6:0] last_value    = 7'd0;

    logic [6:0] lfo_expected [$];
    int         errors      = 0;
    int         idle_cycles = 0;
    bit         calm        = 1'b0;
    bit         hold_req    = 1'b0;

    midi_synced_lfo u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .realtime_byte (realtime_byte),
        .random_sample (random_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lfo_value     (lfo_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [6:0] shape_point(input logic [6:0] sample);
        int unsigned q;
        int unsigned v;
        bit          neg;
        bit          mirror;
        q      = lfo_phase % 6;
        neg    = lfo_phase >= 12;
        mirror = (lfo_phase >= 6 && lfo_phase < 12) || lfo_phase >= 18;
        if (mirror)
            q = 5 - q;
        case (wave_sel)
            WAVE_RANDOM:   v = sample;
            WAVE_SQUARE:   v = amp_set;
            WAVE_TRIANGLE: v = (int'(amp_set) * int'(TRI_Q[q])) >> 6;
            default:       v = (int'(amp_set) * int'(SINE_Q[q])) >> 6;
        endcase
        if (!neg)
            return (v + offset_set > 127) ? 7'd127 : 7'(v + offset_set);
        return (v > offset_set) ? 7'd0 : 7'(offset_set - v);
    endfunction

    // advances the state copy by one midi byte, returns 1 when a value goes out
    function automatic bit step_lfo(input logic [7:0] midi_byte, input logic [6:0] sample,
                                    output logic [6:0] point);
        bit emitted;
        emitted = 1'b0;
        point   = last_value;
        if (midi_byte == RT_CLOCK)
        begin
            await_tick = 1'b0;
            if (running)
            begin
                tick_count = tick_count - 8'd1;
                if (tick_count == 8'd0)
                    point_pending = 1'b1;
            end
        end
        else if (running)
        begin
            if (midi_byte == RT_STOP)
                running = 1'b0;
        end
        else if (midi_byte == RT_START || midi_byte == RT_CONTINUE)
        begin
            if (midi_byte == RT_START)
                lfo_phase = 5'd0;
            running = 1'b1;
        end

        if (lfo_on && point_pending && !await_tick)
        begin
            point_pending = 1'b0;
            point         = shape_point(sample);
            lfo_phase     = (lfo_phase == PERIOD_POINTS - 1) ? 5'd0 : lfo_phase + 5'd1;
            if (point != last_value)
            begin
                last_value = point;
                emitted    = 1'b1;
            end
            await_tick = 1'b1;
            tick_count = 8'(rate_set) * 8'd2 + 8'd2;
        end
        return emitted;
    endfunction

    task automatic send_midi(input logic [7:0] midi_byte, input logic [6:0] sample,
                             input bit typed, input logic [6:0] want);
        logic [6:0] point;
        bit         emitted;
        if (!calm && $urandom_range(5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        realtime_byte <= midi_byte;
        random_sample <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        emitted = step_lfo(midi_byte, sample, point);
        if (typed)
            lfo_expected.push_back(want);
        else if (emitted)
            lfo_expected.push_back(point);
    endtask

    // waits for the block to go idle, then writes one register
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
        in_valid <= 1'b0;
        while (lfo_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LFO_ENABLE: lfo_on     = val[0];
            REG_WAVEFORM:   wave_sel   = wave_t'(val[1:0]);
            REG_AMPLITUDE:  amp_set    = val;
            REG_OFFSET:     offset_set = val;
            REG_RATE:       rate_set   = val[3:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // result side: checks each transfer, stalls in bursts
    initial
    begin
        logic [6:0] want;
        @(posedge rst_n);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (lfo_expected.size() == 0)
                begin
                    $error("lfo_value: expected none, got %0d", lfo_value);
                    errors++;
                end
                else
                begin
                    want = lfo_expected.pop_front();
                    if (lfo_value !== want)
                    begin
                        $error("lfo_value: expected %0d, got %0d", want, lfo_value);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        int unsigned pick;
        logic [7:0]  midi_byte;
        logic [6:0]  amp_val;
        logic [3:0]  rate_val;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_REG)
                write_reg(row.code[CFG_INDEX_W-1:0], row.arg);
            else
                for (int n = 0; n < row.count; n++)
                    send_midi(row.code, row.arg, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            calm = (p == 3) || (p == NUM_PHASES - 1);
            pick = $urandom_range(3);
            amp_val  = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(127));
            rate_val = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(2));
            case (p)
                0:
                begin
                    write_reg(REG_LFO_ENABLE, 7'd1);
                    write_reg(REG_WAVEFORM, 7'(WAVE_TRIANGLE));
                    write_reg(REG_AMPLITUDE, 7'd127);
                    write_reg(REG_OFFSET, 7'd0);
                    write_reg(REG_RATE, 7'd0);
                end
                1:
                begin
                    write_reg(REG_LFO_ENABLE, 7'd1);
                    write_reg(REG_WAVEFORM, 7'(WAVE_RANDOM));
                    write_reg(REG_AMPLITUDE, 7'd0);
                    write_reg(REG_OFFSET, 7'd127);
                    write_reg(REG_RATE, 7'd15);
                end
                2:
                begin
                    write_reg(REG_LFO_ENABLE, 7'd1);
                    write_reg(REG_WAVEFORM, 7'(WAVE_RANDOM));
                    write_reg(REG_AMPLITUDE, amp_val);
                    write_reg(REG_OFFSET, 7'd64);
                    write_reg(REG_RATE, 7'd0);
                end
                default:
                begin
                    write_reg(REG_LFO_ENABLE, 7'($urandom_range(4) != 0));
                    write_reg(REG_WAVEFORM, 7'($urandom_range(3)));
                    write_reg(REG_AMPLITUDE, amp_val);
                    write_reg(REG_OFFSET, 7'($urandom_range(127)));
                    write_reg(REG_RATE, 7'(rate_val));
                end
            endcase
            write_reg(3'($urandom_range(2**CFG_INDEX_W - 1, REG_UNMAPPED)),
                      7'($urandom_range(127)));

            // long receiver hold while items keep coming
            if (p == 2)
                hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    midi_byte = RT_CLOCK;
                else if (pick < 74)
                    midi_byte = RT_START;
                else if (pick < 78)
                    midi_byte = RT_CONTINUE;
                else if (pick < 82)
                    midi_byte = RT_STOP;
                else
                    midi_byte = 8'($urandom_range(255));
                send_midi(midi_byte, 7'($urandom_range(127)), 1'b0, 7'd0);
            end
        end

        in_valid <= 1'b0;
        while (lfo_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES + 1) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
